### sv/plam_pkg.sv
// ----------------------------------------------------------------------------
// plam_pkg: shared definitions for the piecewise-linear age map
// Widths, reset breakpoints, codes and the front-to-back queue entry.
// ----------------------------------------------------------------------------
package plam_pkg;

	localparam int AGE_W           = 16;
	localparam int SEG_W           = 3;
	localparam int MAX_POINTS      = 4;
	localparam int PT_W            = 2;
	localparam int CFG_IDX_W       = 3;
	localparam int NUM_POINTS_DEF  = 4;
	localparam int QUEUE_DEPTH_DEF = 4;
	localparam int WORK_W          = 2 * AGE_W;
	localparam int STEPS_PER_STAGE = 2;
	localparam int DIV_STAGES      = AGE_W / STEPS_PER_STAGE;

	// segment code for values past the last breakpoint
	localparam logic [SEG_W-1:0] SEG_BEYOND = 3'd4;

	// direction of a request
	localparam logic KIND_S2D = 1'b0;
	localparam logic KIND_D2S = 1'b1;

	// low bit of a register index selects the coordinate of a breakpoint
	localparam logic CFG_COORD_SERVER  = 1'b0;
	localparam logic CFG_COORD_DISPLAY = 1'b1;

	localparam logic [AGE_W-1:0] RESET_SERVER [MAX_POINTS] =
		'{16'd5120, 16'd26624, 16'd29952, 16'd30720};
	localparam logic [AGE_W-1:0] RESET_DISPLAY [MAX_POINTS] =
		'{16'd5120, 16'd10240, 16'd14592, 16'd15360};

	// classified request, handed from front to back
	typedef struct packed {
		logic             beyond;
		logic [SEG_W-1:0] seg;
		logic [AGE_W-1:0] s_tgt;
		logic             dt_neg;
		logic [AGE_W-1:0] dt_mag;
		logic [AGE_W:0]   dv;
		logic [AGE_W-1:0] span;
	} entry_t;

endpackage

### sv/plam_front.sv
// ----------------------------------------------------------------------------
// plam_front: breakpoint registers and segment classification
// Holds the table, finds the first matching segment and forms the deltas.
// ----------------------------------------------------------------------------
module plam_front #(
	parameter int NUM_POINTS = plam_pkg::NUM_POINTS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_wr_en,
	input  logic [plam_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [plam_pkg::AGE_W-1:0]       cfg_data,
	input  logic                             kind,
	input  logic [plam_pkg::AGE_W-1:0]       age_value,
	output plam_pkg::entry_t                 entry
);
	import plam_pkg::*;

	logic [AGE_W-1:0] serv_q [NUM_POINTS];
	logic [AGE_W-1:0] disp_q [NUM_POINTS];

	logic             found;
	logic [SEG_W-1:0] seg;
	logic [AGE_W-1:0] s_src, s_tgt, e_src, e_tgt;
	logic [AGE_W-1:0] prev_src, prev_tgt, pt_src, pt_tgt;
	logic [AGE_W:0]   dt, dt_inv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_POINTS; i++) begin
				serv_q[i] <= RESET_SERVER[i];
				disp_q[i] <= RESET_DISPLAY[i];
			end
		end else if (cfg_wr_en) begin
			for (int i = 0; i < NUM_POINTS; i++) begin
				if (cfg_index[CFG_IDX_W-1:1] == PT_W'(i)) begin
					if (cfg_index[0] == CFG_COORD_DISPLAY) begin
						disp_q[i] <= cfg_data;
					end else begin
						serv_q[i] <= cfg_data;
					end
				end
			end
		end
	end

	// walk from the origin, take the first segment with start <= v < end
	always_comb begin
		found    = 1'b0;
		seg      = SEG_BEYOND;
		s_src    = '0;
		s_tgt    = '0;
		e_src    = '0;
		e_tgt    = '0;
		prev_src = '0;
		prev_tgt = '0;
		pt_src   = '0;
		pt_tgt   = '0;
		for (int i = 0; i < NUM_POINTS; i++) begin
			pt_src = (kind == KIND_D2S) ? disp_q[i] : serv_q[i];
			pt_tgt = (kind == KIND_D2S) ? serv_q[i] : disp_q[i];
			if (!found && prev_src <= age_value && age_value < pt_src) begin
				found = 1'b1;
				seg   = SEG_W'(i);
				s_src = prev_src;
				s_tgt = prev_tgt;
				e_src = pt_src;
				e_tgt = pt_tgt;
			end
			prev_src = pt_src;
			prev_tgt = pt_tgt;
		end
		if (!found) begin
			s_src = prev_src;
			s_tgt = prev_tgt;
			e_src = prev_src;
			e_tgt = prev_tgt;
		end
	end

	assign dt     = {1'b0, e_tgt} - {1'b0, s_tgt};
	assign dt_inv = '0 - dt;

	assign entry.beyond = !found;
	assign entry.seg    = seg;
	assign entry.s_tgt  = s_tgt;
	assign entry.dt_neg = dt[AGE_W];
	assign entry.dt_mag = dt[AGE_W] ? dt_inv[AGE_W-1:0] : dt[AGE_W-1:0];
	assign entry.dv     = {1'b0, age_value} - {1'b0, s_src};
	assign entry.span   = e_src - s_src;

endmodule

### sv/plam_queue.sv
// ----------------------------------------------------------------------------
// plam_queue: short request queue between front and back
// Flip-flop FIFO of classified entries; full and empty decode a registered count.
// ----------------------------------------------------------------------------
module plam_queue #(
	parameter int DEPTH = plam_pkg::QUEUE_DEPTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  plam_pkg::entry_t wr_data,
	input  logic             rd_en,
	output plam_pkg::entry_t rd_data,
	output logic             empty,
	output logic             full
);
	import plam_pkg::*;

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	entry_t           mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign rd_data = mem_q[rd_ptr_q];
	assign empty   = (count_q == '0);
	assign full    = (count_q == CNT_W'(DEPTH));

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + 1'b1;
			end else if (rd_en && !wr_en) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

### sv/plam_back.sv
// ----------------------------------------------------------------------------
// plam_back: interpolation pipeline
// Multiply, restoring divide two quotient bits per stage, offset, output register.
// ----------------------------------------------------------------------------
module plam_back (
	input  logic                         clk,
	input  logic                         arst_n,
	input  plam_pkg::entry_t             q_data,
	input  logic                         q_empty,
	output logic                         q_pop,
	output logic [plam_pkg::AGE_W-1:0]   converted_age,
	output logic [plam_pkg::SEG_W-1:0]   segment_used,
	output logic                         clipped,
	output logic                         empty,
	input  logic                         pop
);
	import plam_pkg::*;

	typedef struct packed {
		logic              beyond;
		logic [SEG_W-1:0]  seg;
		logic [AGE_W-1:0]  s_tgt;
		logic              neg;
		logic [AGE_W-1:0]  span;
		logic [WORK_W-1:0] work;
		logic [AGE_W-1:0]  bres;
		logic              clip;
	} stage_t;

	// one restoring step: upper half is the remainder, quotient bits shift in below
	function automatic logic [WORK_W-1:0] div_step(input logic [WORK_W-1:0] w,
	                                               input logic [AGE_W-1:0] d);
		logic [AGE_W:0] t;
		logic           qb;
		t  = {w[WORK_W-1:AGE_W], w[AGE_W-1]};
		qb = (t >= {1'b0, d});
		if (qb) begin
			t = t - {1'b0, d};
		end
		return {t[AGE_W-1:0], w[AGE_W-2:0], qb};
	endfunction

	logic              adv;
	logic [WORK_W-1:0] prod;
	logic [AGE_W+1:0]  bsum;
	stage_t            mul_d, mul_s1;
	logic              mul_vld_s1;
	stage_t            div_in [DIV_STAGES];
	stage_t            div_d  [DIV_STAGES];
	stage_t            div_s  [DIV_STAGES];
	logic              div_vld_s [DIV_STAGES];
	logic [AGE_W-1:0]  quot;
	logic [AGE_W-1:0]  res;
	logic              out_vld_q;

	// the whole pipeline moves unless a finished result waits unpopped
	assign adv   = !out_vld_q || pop;
	assign q_pop = adv && !q_empty;

	assign prod = q_data.dt_mag * q_data.dv[AGE_W-1:0];
	assign bsum = {2'b00, q_data.s_tgt} + {q_data.dv[AGE_W], q_data.dv};

	always_comb begin
		mul_d.beyond = q_data.beyond;
		mul_d.seg    = q_data.seg;
		mul_d.s_tgt  = q_data.s_tgt;
		mul_d.neg    = q_data.dt_neg;
		mul_d.span   = q_data.span;
		mul_d.work   = prod;
		mul_d.bres   = bsum[AGE_W-1:0];
		mul_d.clip   = 1'b0;
		if (q_data.beyond) begin
			if (bsum[AGE_W+1]) begin
				mul_d.bres = '0;
				mul_d.clip = 1'b1;
			end else if (bsum[AGE_W]) begin
				mul_d.bres = '1;
				mul_d.clip = 1'b1;
			end
		end
	end

	always_comb begin
		div_in[0] = mul_s1;
		for (int k = 1; k < DIV_STAGES; k++) begin
			div_in[k] = div_s[k-1];
		end
		for (int k = 0; k < DIV_STAGES; k++) begin
			div_d[k] = div_in[k];
			for (int j = 0; j < STEPS_PER_STAGE; j++) begin
				div_d[k].work = div_step(div_d[k].work, div_d[k].span);
			end
		end
	end

	assign quot = div_s[DIV_STAGES-1].work[AGE_W-1:0];
	assign res  = div_s[DIV_STAGES-1].beyond ? div_s[DIV_STAGES-1].bres :
	              div_s[DIV_STAGES-1].neg    ? div_s[DIV_STAGES-1].s_tgt - quot :
	                                           div_s[DIV_STAGES-1].s_tgt + quot;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mul_vld_s1 <= 1'b0;
			for (int k = 0; k < DIV_STAGES; k++) begin
				div_vld_s[k] <= 1'b0;
			end
			out_vld_q <= 1'b0;
		end else if (adv) begin
			mul_vld_s1   <= !q_empty;
			div_vld_s[0] <= mul_vld_s1;
			for (int k = 1; k < DIV_STAGES; k++) begin
				div_vld_s[k] <= div_vld_s[k-1];
			end
			out_vld_q <= div_vld_s[DIV_STAGES-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			mul_s1 <= mul_d;
			for (int k = 0; k < DIV_STAGES; k++) begin
				div_s[k] <= div_d[k];
			end
			converted_age <= res;
			segment_used  <= div_s[DIV_STAGES-1].seg;
			clipped       <= div_s[DIV_STAGES-1].clip;
		end
	end

	assign empty = !out_vld_q;

endmodule

### sv/piecewise_linear_age_map.sv
// ----------------------------------------------------------------------------
// piecewise_linear_age_map: four-breakpoint piecewise-linear age conversion
// Forward (server to display) or inverse mapping of 8.8 ages, one per request.
// ----------------------------------------------------------------------------
//
// channel   handshake          payload
// -------   ----------------   -----------------------------------------
// input     push / full        kind, age_value
// result    empty / pop        converted_age, segment_used, clipped
// config    cfg_wr_en          cfg_index, cfg_data (no wait, no read-back)
//
// One request per cycle sustained while results are popped. A request passes
// through the queue, one multiply stage, eight divide stages retiring two
// quotient bits each, and one output register before it leaves the result ports.
// Reset restores the default breakpoints and empties queue and pipeline.
// While a result waits unpopped the back pipeline holds; the front keeps
// taking requests until the queue fills, then raises full.
//
module piecewise_linear_age_map #(
	parameter int NUM_POINTS  = plam_pkg::NUM_POINTS_DEF,
	parameter int QUEUE_DEPTH = plam_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wr_en,
	input  logic [plam_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [plam_pkg::AGE_W-1:0]     cfg_data,
	input  logic                           push,
	output logic                           full,
	input  logic                           kind,
	input  logic [plam_pkg::AGE_W-1:0]     age_value,
	output logic                           empty,
	input  logic                           pop,
	output logic [plam_pkg::AGE_W-1:0]     converted_age,
	output logic [plam_pkg::SEG_W-1:0]     segment_used,
	output logic                           clipped
);
	import plam_pkg::*;

	entry_t front_entry;
	entry_t queue_head;
	logic   queue_empty;
	logic   queue_pop;
	logic   accept;

	// a request enters the queue at once; classification is combinational
	assign accept = push && !full;

	// breakpoint table and segment search
	plam_front #(
		.NUM_POINTS(NUM_POINTS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.kind     (kind),
		.age_value(age_value),
		.entry    (front_entry)
	);

	// decouple classification from the arithmetic so each side stalls alone
	plam_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (accept),
		.wr_data(front_entry),
		.rd_en  (queue_pop),
		.rd_data(queue_head),
		.empty  (queue_empty),
		.full   (full)
	);

	// multiply, divide, offset, hold the result until popped
	plam_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_data       (queue_head),
		.q_empty      (queue_empty),
		.q_pop        (queue_pop),
		.converted_age(converted_age),
		.segment_used (segment_used),
		.clipped      (clipped),
		.empty        (empty),
		.pop          (pop)
	);

endmodule
